### src/use_count_ordered_cache_policy_macros.svh
// Assertion macros for the use-count ordered cache policy.
`ifndef USE_COUNT_ORDERED_CACHE_POLICY_MACROS_SVH
`define USE_COUNT_ORDERED_CACHE_POLICY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UCOCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UCOCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ucocp_pkg.sv
// Types and constants of the use-count ordered cache policy.
`default_nettype none
package ucocp_pkg;

  // list holds at most CAPACITY+1 entries; slot and count fields are 9 bits, enough for 257
  localparam int unsigned CAPACITY = 256;

  localparam int unsigned TAG_W    = 16;
  localparam int unsigned USES_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [USES_W-1:0] USES_MAX = '1;

  localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MOVE_RD,
    ST_MOVE_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [USES_W-1:0] uses;
  } entry_t;

endpackage
`default_nettype wire

### src/ucocp_in_if.sv
// Request channel: glyph index and backing-store flag.
`default_nettype none
interface ucocp_in_if;
  logic                           valid;
  logic                           ready;
  logic [ucocp_pkg::TAG_W-1:0]    glyph_index;
  logic                           backing_found;

  modport source (output valid, output glyph_index, output backing_found, input ready);
  modport sink   (input valid, input glyph_index, input backing_found, output ready);
endinterface
`default_nettype wire

### src/ucocp_out_if.sv
// Result channel: lookup status, slot, count and list size.
`default_nettype none
interface ucocp_out_if;
  logic                             valid;
  logic                             ready;
  logic [ucocp_pkg::STATUS_W-1:0]   status;
  logic [ucocp_pkg::POS_W-1:0]      position;
  logic [ucocp_pkg::USES_W-1:0]     use_count;
  logic                             trimmed;
  logic [ucocp_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output position, output use_count,
                  output trimmed, output entry_count, input ready);
  modport sink   (input valid, input status, input position, input use_count,
                  input trimmed, input entry_count, output ready);
endinterface
`default_nettype wire

### src/ucocp_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module ucocp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/use_count_ordered_cache_policy.sv
// Use-count ordered glyph cache policy. The list of (glyph, count) entries,
// sorted by descending count, lives in one RAM of CAPACITY+1 words. A request
// walks the list from slot 0, reading then comparing each slot examined,
// until it matches or passes the end. A hit or an insert then walks back
// toward the head, reading then comparing each slot, moving each overtaken
// entry down one slot, and writes the entry where the walk stops. One request
// is in flight at a time; the next one is taken as soon as the result sits in
// the output register. No clearing pass: slots beyond the length are never
// read.
`default_nettype none
`include "use_count_ordered_cache_policy_macros.svh"
module use_count_ordered_cache_policy (
  input wire logic    clk,
  input wire logic    rst_n,
  ucocp_in_if.sink    in_ch,
  ucocp_out_if.source out_ch
);

  localparam int unsigned DEPTH = ucocp_pkg::CAPACITY + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(ucocp_pkg::CAPACITY + 2);
  localparam int unsigned HALF  = ucocp_pkg::CAPACITY / 2;
  localparam int unsigned EW    = $bits(ucocp_pkg::entry_t);

  ucocp_pkg::state_t state_r, state_nxt;

  logic [ucocp_pkg::TAG_W-1:0]    idx_r, idx_nxt;
  logic                           bf_r, bf_nxt;
  logic [LW-1:0]                  len_r, len_nxt;
  logic [LW-1:0]                  k_r, k_nxt;
  logic [ucocp_pkg::USES_W-1:0]   cnt_r, cnt_nxt;
  logic                           trim_r, trim_nxt;
  logic [ucocp_pkg::STATUS_W-1:0] stat_r, stat_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [ucocp_pkg::STATUS_W-1:0]   o_status_r, o_status_nxt;
  logic [ucocp_pkg::POS_W-1:0]      o_pos_r, o_pos_nxt;
  logic [ucocp_pkg::USES_W-1:0]     o_uses_r, o_uses_nxt;
  logic                             o_trim_r, o_trim_nxt;
  logic [ucocp_pkg::COUNT_W-1:0]    o_count_r, o_count_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  ucocp_pkg::entry_t      ram_wentry, ram_rentry;
  logic [EW-1:0]          ram_rdata;

  logic [LW-1:0]          k_dec;
  logic [LW+8:0]          k_ext, len_ext;
  logic                   in_acc;

  assign ram_rentry = ucocp_pkg::entry_t'(ram_rdata);
  assign k_dec      = k_r - LW'(1);
  assign in_acc     = in_ch.valid && in_ch.ready;

  ucocp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ucocp_pkg::ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bf_r       <= bf_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    trim_r     <= trim_nxt;
    stat_r     <= stat_nxt;
    o_status_r <= o_status_nxt;
    o_pos_r    <= o_pos_nxt;
    o_uses_r   <= o_uses_nxt;
    o_trim_r   <= o_trim_nxt;
    o_count_r  <= o_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    bf_nxt        = bf_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    trim_nxt      = trim_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_pos_nxt     = o_pos_r;
    o_uses_nxt    = o_uses_r;
    o_trim_nxt    = o_trim_r;
    o_count_nxt   = o_count_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[AW-1:0];
    ram_wentry    = '{tag: idx_r, uses: cnt_r};
    ram_raddr     = k_r[AW-1:0];
    in_ch.ready   = 1'b0;
    k_ext         = (LW+9)'(k_r);
    len_ext       = (LW+9)'(len_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ucocp_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          idx_nxt   = in_ch.glyph_index;
          bf_nxt    = in_ch.backing_found;
          k_nxt     = '0;
          trim_nxt  = 1'b0;
          state_nxt = ucocp_pkg::ST_SCAN_RD;
        end
      end
      ucocp_pkg::ST_SCAN_RD: begin
        if (k_r == len_r) begin
          if (bf_r) begin
            // miss with supply: trim tail half if over capacity, then insert
            if (len_r > LW'(ucocp_pkg::CAPACITY)) begin
              len_nxt  = len_r - LW'(HALF);
              k_nxt    = len_r - LW'(HALF);
              trim_nxt = 1'b1;
            end
            cnt_nxt   = ucocp_pkg::USES_W'(1);
            stat_nxt  = ucocp_pkg::STATUS_INSERTED;
            state_nxt = ucocp_pkg::ST_MOVE_RD;
          end else begin
            stat_nxt  = ucocp_pkg::STATUS_MISSING;
            state_nxt = ucocp_pkg::ST_DONE;
          end
        end else begin
          state_nxt = ucocp_pkg::ST_SCAN_CMP;
        end
      end
      ucocp_pkg::ST_SCAN_CMP: begin
        if (ram_rentry.tag == idx_r) begin
          cnt_nxt   = (ram_rentry.uses == ucocp_pkg::USES_MAX) ? ram_rentry.uses
                                                              : ram_rentry.uses + 1'b1;
          stat_nxt  = ucocp_pkg::STATUS_HIT;
          state_nxt = ucocp_pkg::ST_MOVE_RD;
        end else begin
          k_nxt     = k_r + LW'(1);
          state_nxt = ucocp_pkg::ST_SCAN_RD;
        end
      end
      ucocp_pkg::ST_MOVE_RD: begin
        if (k_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ucocp_pkg::ST_DONE;
        end else begin
          ram_raddr = k_dec[AW-1:0];
          state_nxt = ucocp_pkg::ST_MOVE_CMP;
        end
      end
      ucocp_pkg::ST_MOVE_CMP: begin
        ram_we = 1'b1;
        if (ram_rentry.uses <= cnt_r) begin
          // overtaken entry slides down one slot
          ram_wentry = ram_rentry;
          k_nxt      = k_dec;
          state_nxt  = ucocp_pkg::ST_MOVE_RD;
        end else begin
          state_nxt = ucocp_pkg::ST_DONE;
        end
      end
      ucocp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = stat_r;
          o_trim_nxt    = trim_r;
          if (stat_r == ucocp_pkg::STATUS_MISSING) begin
            o_pos_nxt   = '0;
            o_uses_nxt  = '0;
            o_count_nxt = len_ext[ucocp_pkg::COUNT_W-1:0];
          end else begin
            o_pos_nxt  = k_ext[ucocp_pkg::POS_W-1:0];
            o_uses_nxt = cnt_r;
            if (stat_r == ucocp_pkg::STATUS_INSERTED) begin
              len_nxt     = len_r + LW'(1);
              len_ext     = (LW+9)'(len_r) + (LW+9)'(1);
            end
            o_count_nxt = len_ext[ucocp_pkg::COUNT_W-1:0];
          end
          state_nxt = ucocp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ucocp_pkg::ST_IDLE;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.position    = o_pos_r;
  assign out_ch.use_count   = o_uses_r;
  assign out_ch.trimmed     = o_trim_r;
  assign out_ch.entry_count = o_count_r;

  `UCOCP_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LW'(DEPTH), "list length over bound")
  `UCOCP_ASSERT_NXT(a_accept_scan, in_acc, state_r == ucocp_pkg::ST_SCAN_RD, "request not scanned")
  `UCOCP_ASSERT_IMP(a_move_count, state_r == ucocp_pkg::ST_MOVE_CMP, cnt_r != '0, "zero count moved")
  `UCOCP_ASSERT_IMP(a_scan_bound, state_r == ucocp_pkg::ST_SCAN_CMP, k_r < len_r, "scan past end")
  `UCOCP_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == ucocp_pkg::ST_DONE, "word without done")

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the use-count ordered cache policy: directed table, then random traffic.
`default_nettype none
module tb;

  localparam int unsigned CAP       = ucocp_pkg::CAPACITY;
  localparam int unsigned DEPTH     = CAP + 1;
  localparam int unsigned N_RANDOM  = 1930;
  localparam int unsigned MAX_CYCLE = 8000000;
  localparam int unsigned DRAIN     = 1200;

  typedef struct packed {
    logic [ucocp_pkg::STATUS_W-1:0] status;
    logic [ucocp_pkg::POS_W-1:0]    position;
    logic [ucocp_pkg::USES_W-1:0]   use_count;
    logic                           trimmed;
    logic [ucocp_pkg::COUNT_W-1:0]  entry_count;
  } lookup_res_t;

  typedef struct {
    logic [ucocp_pkg::TAG_W-1:0] glyph;
    logic                        backing;
    bit                          typed;
    lookup_res_t                 res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ucocp_in_if  in_ch();
  ucocp_out_if out_ch();

  use_count_ordered_cache_policy dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the list
  logic [ucocp_pkg::TAG_W-1:0]  tag_mem  [DEPTH];
  logic [ucocp_pkg::USES_W-1:0] uses_mem [DEPTH];
  int unsigned                  n_entries;

  lookup_res_t pending_q[$];
  int unsigned errors, n_hits, n_inserts, n_missing, n_trims, n_results;
  int unsigned send_idle_pct, recv_idle_pct;
  longint unsigned cycles;

  function automatic lookup_res_t predict_lookup(logic [ucocp_pkg::TAG_W-1:0] g, logic b);
    lookup_res_t r;
    int unsigned i, dest, k, len;
    logic [16:0] c;
    r = '0;
    len = n_entries;
    for (i = 0; i < len; i++)
      if (tag_mem[i] == g) break;
    if (i < len) begin
      c = 17'(uses_mem[i]);
      if (c < 17'(ucocp_pkg::USES_MAX)) c++;
      dest = i;
      while (dest > 0 && 17'(uses_mem[dest-1]) <= c) dest--;
      for (k = i; k > dest; k--) begin
        tag_mem[k]  = tag_mem[k-1];
        uses_mem[k] = uses_mem[k-1];
      end
      tag_mem[dest]  = g;
      uses_mem[dest] = c[ucocp_pkg::USES_W-1:0];
      r.status    = ucocp_pkg::STATUS_HIT;
      r.position  = dest[ucocp_pkg::POS_W-1:0];
      r.use_count = c[ucocp_pkg::USES_W-1:0];
    end else if (b) begin
      if (len > CAP) begin
        len -= CAP / 2;
        r.trimmed = 1'b1;
      end
      dest = len;
      while (dest > 0 && uses_mem[dest-1] <= 16'd1) dest--;
      for (k = len; k > dest; k--) begin
        tag_mem[k]  = tag_mem[k-1];
        uses_mem[k] = uses_mem[k-1];
      end
      tag_mem[dest]  = g;
      uses_mem[dest] = 16'd1;
      len++;
      r.status    = ucocp_pkg::STATUS_INSERTED;
      r.position  = dest[ucocp_pkg::POS_W-1:0];
      r.use_count = 16'd1;
    end else begin
      r.status = ucocp_pkg::STATUS_MISSING;
    end
    n_entries     = len;
    r.entry_count = len[ucocp_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // drive one request word and record its expectation on acceptance
  task automatic send_request(logic [ucocp_pkg::TAG_W-1:0] g, logic b, bit typed,
                              lookup_res_t tres);
    lookup_res_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.glyph_index   <= g;
    in_ch.backing_found <= b;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_lookup(g, b);
    pending_q.push_back(typed ? tres : p);
  endtask

  // result side: compare and apply backpressure
  always @(posedge clk) begin
    lookup_res_t e, a;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = '{out_ch.status, out_ch.position, out_ch.use_count, out_ch.trimmed,
            out_ch.entry_count};
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result word %p", a);
      end else begin
        e = pending_q.pop_front();
        case (a.status)
          ucocp_pkg::STATUS_HIT:      n_hits++;
          ucocp_pkg::STATUS_INSERTED: n_inserts++;
          default:                    n_missing++;
        endcase
        if (a.trimmed) n_trims++;
        if (a !== e) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d expected st=%0d pos=%0d uses=%0d trim=%0b cnt=%0d,",
                     n_results, e.status, e.position, e.use_count, e.trimmed,
                     e.entry_count);
            $display("       got st=%0d pos=%0d uses=%0d trim=%0b cnt=%0d",
                     a.status, a.position, a.use_count, a.trimmed, a.entry_count);
          end
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles > MAX_CYCLE) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  stim_row_t dir_tbl[$];

  function automatic stim_row_t row(logic [ucocp_pkg::TAG_W-1:0] g, logic b, bit typed = 0,
                                    logic [ucocp_pkg::STATUS_W-1:0] st = '0,
                                    int unsigned pos = 0, int unsigned u = 0,
                                    int unsigned cnt = 0);
    stim_row_t s;
    s.glyph = g; s.backing = b; s.typed = typed;
    s.res = '{st, pos[ucocp_pkg::POS_W-1:0], u[ucocp_pkg::USES_W-1:0], 1'b0,
              cnt[ucocp_pkg::COUNT_W-1:0]};
    return s;
  endfunction

  initial begin
    logic [ucocp_pkg::TAG_W-1:0] g;
    logic b;
    logic [31:0] rnd;
    int unsigned sel, n;
    in_ch.valid = 1'b0;
    in_ch.glyph_index = '0;
    in_ch.backing_found = 1'b0;
    n_entries = 0;
    send_idle_pct = 32;
    recv_idle_pct = 82;

    // empty list, extremes, hit, reorder, then a few checked by the predictor
    dir_tbl.push_back(row(16'h0000, 1'b0, 1, ucocp_pkg::STATUS_MISSING, 0, 0, 0));
    dir_tbl.push_back(row(16'hFFFF, 1'b1, 1, ucocp_pkg::STATUS_INSERTED, 0, 1, 1));
    dir_tbl.push_back(row(16'hFFFF, 1'b1, 1, ucocp_pkg::STATUS_HIT, 0, 2, 1));
    dir_tbl.push_back(row(16'h0000, 1'b1, 1, ucocp_pkg::STATUS_INSERTED, 1, 1, 2));
    dir_tbl.push_back(row(16'h0000, 1'b0, 1, ucocp_pkg::STATUS_HIT, 0, 2, 2));
    dir_tbl.push_back(row(16'hAAAA, 1'b0, 1, ucocp_pkg::STATUS_MISSING, 0, 0, 2));
    dir_tbl.push_back(row(16'h5555, 1'b1));
    dir_tbl.push_back(row(16'hAAAA, 1'b1));
    dir_tbl.push_back(row(16'h8000, 1'b1));
    dir_tbl.push_back(row(16'h0001, 1'b1));
    dir_tbl.push_back(row(16'h0001, 1'b0));
    dir_tbl.push_back(row(16'h0001, 1'b0));
    dir_tbl.push_back(row(16'h0001, 1'b1));
    dir_tbl.push_back(row(16'h5555, 1'b0));
    dir_tbl.push_back(row(16'hFFFF, 1'b0));
    dir_tbl.push_back(row(16'h7FFF, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i])
      send_request(dir_tbl[i].glyph, dir_tbl[i].backing, dir_tbl[i].typed, dir_tbl[i].res);

    // mostly hits and inserts so the list fills past capacity and trims
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin send_idle_pct = 82; recv_idle_pct = 32; end
      if (n == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      sel = $urandom_range(99);
      rnd = $urandom;
      if (sel < 55 && n_entries > 0) begin
        if (rnd[20]) g = tag_mem[$urandom_range(n_entries - 1)];
        else g = tag_mem[$urandom_range(n_entries < 8 ? n_entries - 1 : 7)];
        b = rnd[16];
      end else if (sel < 85) begin
        g = rnd[ucocp_pkg::TAG_W-1:0];
        b = 1'b1;
      end else if (sel < 95) begin
        g = rnd[ucocp_pkg::TAG_W-1:0];
        b = 1'b0;
      end else begin
        g = {12'd0, rnd[3:0]};
        b = rnd[16];
      end
      send_request(g, b, 0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Ran %0d requests: %0d hits, %0d inserts, %0d unavailable misses, %0d trims.",
             n_results, n_hits, n_inserts, n_missing, n_trims);
    if (errors == 0 && pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/ucocp_pkg.sv
src/ucocp_in_if.sv
src/ucocp_out_if.sv
src/ucocp_ram.sv
src/use_count_ordered_cache_policy.sv
dv/tb.sv
